// ===== sv/keepalive_timeout_table_macros.svh =====
// assertion macros for the keepalive timeout table
// no dependencies; included by keepalive_timeout_table.sv, which carries the assertions
`ifndef KEEPALIVE_TIMEOUT_TABLE_MACROS_SVH
`define KEEPALIVE_TIMEOUT_TABLE_MACROS_SVH

`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define KTT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// condition must never be true outside reset
`define KTT_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);
`else
`define KTT_ASSERT(label, clk, rst, prop, msg)
`define KTT_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ===== sv/ktt_pkg.sv =====
// shared widths, action codes and controller/datapath interface types
// no dependencies
package ktt_pkg;

  localparam int ID_W     = 6;
  localparam int LIMIT_W  = 16;
  localparam int TIME_W   = 32;
  localparam int ACT_W    = 3;
  localparam int ID_SPACE = 64;

  localparam logic [ACT_W-1:0] ACT_START    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ELAPSED  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RESTART  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PRESENCE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SWEEP    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_TICK     = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch the incoming item
    logic tick;        // advance the seconds counter
    logic do_single;   // execute a single-entry action and emit its result
    logic scan_clear;  // start a sweep
    logic scan_sel;    // table read address comes from the scan counter
    logic scan_hit;    // remove the scanned entry, push it to pending
    logic scan_next;   // advance the scan counter
    logic flush;       // emit the pending sweep item as the last one
  } ktt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take an item this cycle
    logic hit;         // scanned entry is valid and expired
    logic scan_end;    // scan counter is on the final entry
    logic pend_valid;  // a sweep item is held back
  } ktt_stat_t;

endpackage

// ===== sv/ktt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module ktt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ktt_ctrl.sv =====
// control state machine: accepts items, sequences single actions and sweeps
// depends on ktt_pkg
module ktt_ctrl
  import ktt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] in_action,
  output logic             in_ready,
  input  ktt_stat_t        stat,
  output ktt_cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_EXEC     = 5'b00010,
    S_SCAN_RD  = 5'b00100,
    S_SCAN_CHK = 5'b01000,
    S_FLUSH    = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_action) inside
            ACT_START, ACT_ELAPSED, ACT_DELETE, ACT_RESTART, ACT_PRESENCE: begin
              state_next = S_EXEC;
            end
            ACT_SWEEP: begin
              cmd.scan_clear = 1'b1;
              state_next     = S_SCAN_RD;
            end
            ACT_TICK: begin
              cmd.tick = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.do_single = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_sel = 1'b1;
        state_next   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_sel = 1'b1;
        // a hit must wait while an older held item cannot go out
        if (!stat.hit || !stat.pend_valid || stat.out_free) begin
          cmd.scan_hit = stat.hit;
          if (stat.scan_end) begin
            state_next = S_FLUSH;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = S_SCAN_RD;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ktt_datapath.sv =====
// datapath: valid bits, start/limit rams, seconds counter, scan and output registers
// depends on ktt_pkg and ktt_ram
module ktt_datapath
  import ktt_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  ktt_cmd_t           cmd,
  output ktt_stat_t          stat,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [ID_W-1:0]    in_id,
  input  logic [LIMIT_W-1:0] in_limit,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [ID_W-1:0]    out_id,
  output logic               out_present,
  output logic [TIME_W-1:0]  out_elapsed,
  output logic               out_expired,
  output logic               out_last
);

  // ids are six bits wide, so no more than ID_SPACE entries are reachable
  localparam int SPAN  = (ENTRIES < ID_SPACE) ? ENTRIES : ID_SPACE;
  localparam int IDX_W = $clog2(SPAN);

  logic [ACT_W-1:0]   cmd_act;
  logic [ID_W-1:0]    cmd_id;
  logic [LIMIT_W-1:0] cmd_limit;
  logic               cmd_inside;
  logic [IDX_W-1:0]   cmd_idx;

  logic [SPAN-1:0]    valid;
  logic [TIME_W-1:0]  now;
  logic [IDX_W-1:0]   scan;
  logic               pend_valid;
  logic [IDX_W-1:0]   pend_id;

  logic [IDX_W-1:0]   rd_addr;
  logic [TIME_W-1:0]  start_rd;
  logic [LIMIT_W-1:0] limit_rd;
  logic [TIME_W-1:0]  diff;
  logic               was;
  logic               start_we;
  logic               limit_we;
  logic               out_free;
  logic               emit_pend;

  assign cmd_idx   = cmd_id[IDX_W-1:0];
  assign was       = cmd_inside && valid[cmd_idx];
  assign diff      = now - start_rd;
  assign out_free  = !out_valid || out_ready;
  assign emit_pend = (cmd.scan_hit && pend_valid) || cmd.flush;

  assign rd_addr = cmd.scan_sel ? scan : (cmd.load ? in_id[IDX_W-1:0] : cmd_idx);

  assign start_we = cmd.do_single &&
                    ((cmd_act == ACT_START && cmd_inside) || (cmd_act == ACT_RESTART && was));
  assign limit_we = cmd.do_single && cmd_act == ACT_START && cmd_inside;

  ktt_ram #(.WIDTH(TIME_W), .DEPTH(SPAN)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (cmd_idx),
    .wdata (now),
    .raddr (rd_addr),
    .rdata (start_rd)
  );

  ktt_ram #(.WIDTH(LIMIT_W), .DEPTH(SPAN)) u_limit_ram (
    .clk   (clk),
    .we    (limit_we),
    .waddr (cmd_idx),
    .wdata (cmd_limit),
    .raddr (rd_addr),
    .rdata (limit_rd)
  );

  assign stat.out_free   = out_free;
  assign stat.hit        = valid[scan] && (diff >= TIME_W'(limit_rd));
  assign stat.scan_end   = (scan == IDX_W'(SPAN - 1));
  assign stat.pend_valid = pend_valid;

  // latched item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_act    <= in_action;
      cmd_id     <= in_id;
      cmd_limit  <= in_limit;
      cmd_inside <= ({1'b0, in_id} < (ID_W + 1)'(SPAN));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      now        <= '0;
      scan       <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.tick) begin
        now <= now + 1'b1;
      end
      if (cmd.do_single && cmd_inside) begin
        if (cmd_act == ACT_START) begin
          valid[cmd_idx] <= 1'b1;
        end else if (cmd_act == ACT_DELETE) begin
          valid[cmd_idx] <= 1'b0;
        end
      end
      if (cmd.scan_hit) begin
        valid[scan] <= 1'b0;
      end
      if (cmd.scan_clear) begin
        scan <= '0;
      end else if (cmd.scan_next) begin
        scan <= scan + 1'b1;
      end
      if (cmd.scan_clear || cmd.flush) begin
        pend_valid <= 1'b0;
      end else if (cmd.scan_hit) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_hit) begin
      pend_id <= scan;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.do_single || emit_pend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_single) begin
      out_id      <= cmd_id;
      out_present <= was;
      out_elapsed <= (cmd_act == ACT_ELAPSED && was) ? diff : '0;
      out_expired <= 1'b0;
      out_last    <= 1'b1;
    end else if (emit_pend) begin
      out_id      <= ID_W'(pend_id);
      out_present <= 1'b1;
      out_elapsed <= '0;
      out_expired <= 1'b1;
      out_last    <= cmd.flush;
    end
  end

endmodule

// ===== sv/keepalive_timeout_table.sv =====
// single-entry actions (start, queries, delete, restart): latched on accept, result written by EXEC
// tick and unused codes: no result; sweep: one table read and one expiry compare per entry,
//   then a flush of the held item; stalls while results back up
// one item in flight at a time; results sit in an output register, so the next item
//   is accepted while the last result is still waiting
// reset clears all valid bits and the seconds counter at once; no clearing pass
`include "keepalive_timeout_table_macros.svh"

module keepalive_timeout_table
  import ktt_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // entry_id [5:0], timeout_seconds [21:6], zero pad
  input  logic [2:0]  s_axis_tuser,   // action [2:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // report_id [5:0], present [6],
                                      // elapsed_seconds [38:7], zero pad
  output logic [0:0]  m_axis_tuser,   // expired [0]
  output logic        m_axis_tlast    // last item caused by the input item
);

  ktt_cmd_t  cmd;
  ktt_stat_t stat;

  // unpacked input fields
  logic [ACT_W-1:0]   in_action;
  logic [ID_W-1:0]    in_id;
  logic [LIMIT_W-1:0] in_limit;

  // result fields from the output register
  logic [ID_W-1:0]    out_id;
  logic               out_present;
  logic [TIME_W-1:0]  out_elapsed;
  logic               out_expired;

  // result port checks
  logic               expired_item;
  logic               expired_ok;
  logic               single_item;

  assign in_action = s_axis_tuser;
  assign in_id     = s_axis_tdata[5:0];
  assign in_limit  = s_axis_tdata[21:6];

  // controller: decodes the action, walks the sweep, waits on the output register
  ktt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (in_action),
    .in_ready  (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: table storage, seconds counter, expiry compare, result register
  ktt_datapath #(.ENTRIES(ENTRIES)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_action   (in_action),
    .in_id       (in_id),
    .in_limit    (in_limit),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_id      (out_id),
    .out_present (out_present),
    .out_elapsed (out_elapsed),
    .out_expired (out_expired),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_elapsed, out_present, out_id};
  assign m_axis_tuser = out_expired;

  assign expired_item = m_axis_tvalid && out_expired;
  assign expired_ok   = out_present && (out_elapsed == '0);
  assign single_item  = m_axis_tvalid && !out_expired;

  // a removed entry was present and carries no elapsed time
  `KTT_ASSERT(a_expired_fields, clk, rst, expired_item |-> expired_ok, "bad expired item")
  // a single-entry action gives exactly one item, so it is always the last
  `KTT_ASSERT(a_single_last, clk, rst, single_item |-> m_axis_tlast, "single item not last")
  // no sweep item may be held back once the block takes new items
  `KTT_ASSERT_NEVER(a_no_pend, clk, rst, s_axis_tready && stat.pend_valid, "item left pending")

endmodule

// ===== tb/keepalive_timeout_table_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for keepalive_timeout_table: directed and random timer requests
// depends on ktt_pkg and the keepalive_timeout_table rtl; scoreboard class predicts results

module keepalive_timeout_table_tb;
  import ktt_pkg::*;

  // action code the block must ignore
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 146;
  // a sweep walks every table entry; the tail leaves margin for it
  localparam int TAIL_CYCLES = 2 * ID_SPACE + 80;

  // one result item, unpacked
  typedef struct {
    logic [ID_W-1:0]   id;
    logic              present;
    logic [TIME_W-1:0] elapsed;
    logic              expired;
    logic              last;
  } timer_report_t;

  // timer table predictor and queue of expected reports
  class timer_scoreboard;
    bit                valid_q[ID_SPACE];
    logic [TIME_W-1:0] started[ID_SPACE];
    logic [LIMIT_W-1:0] idle_limit[ID_SPACE];
    logic [TIME_W-1:0] seconds;
    timer_report_t     expected_reports[$];
    int                errors;

    function new();
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      seconds = '0;
      errors  = 0;
    endfunction

    function void push_report(logic [ID_W-1:0] id, logic present, logic [TIME_W-1:0] elapsed,
                              logic expired, logic last);
      timer_report_t r;
      r.id      = id;
      r.present = present;
      r.elapsed = elapsed;
      r.expired = expired;
      r.last    = last;
      expected_reports.push_back(r);
    endfunction

    // update the table for one accepted request and queue what it causes
    function void note_request(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                               logic [LIMIT_W-1:0] limit);
      bit was;
      int first_hit;
      was = valid_q[id];
      first_hit = expected_reports.size();
      case (act)
        ACT_START: begin
          valid_q[id]    = 1'b1;
          started[id]    = seconds;
          idle_limit[id] = limit;
          push_report(id, was, '0, 1'b0, 1'b1);
        end
        ACT_ELAPSED: begin
          push_report(id, was, was ? seconds - started[id] : '0, 1'b0, 1'b1);
        end
        ACT_DELETE: begin
          valid_q[id] = 1'b0;
          push_report(id, was, '0, 1'b0, 1'b1);
        end
        ACT_RESTART: begin
          if (was) started[id] = seconds;
          push_report(id, was, '0, 1'b0, 1'b1);
        end
        ACT_PRESENCE: begin
          push_report(id, was, '0, 1'b0, 1'b1);
        end
        ACT_SWEEP: begin
          // ascending id order, elapsed taken modulo 2^32
          for (int i = 0; i < ID_SPACE; i++) begin
            if (valid_q[i] && (seconds - started[i]) >= {16'd0, idle_limit[i]}) begin
              valid_q[i] = 1'b0;
              push_report(i[ID_W-1:0], 1'b1, '0, 1'b1, 1'b0);
            end
          end
          // mark the final removal of this sweep
          if (expected_reports.size() > first_hit)
            expected_reports[expected_reports.size()-1].last = 1'b1;
        end
        ACT_TICK: begin
          seconds = seconds + 1'b1;
        end
        default: begin
        end
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare one received result with the oldest expectation
    task check_report(timer_report_t got);
      timer_report_t want;
      if (expected_reports.size() == 0) begin
        report($sformatf("unexpected result id=%0d expired=%0b", got.id, got.expired));
      end else begin
        want = expected_reports.pop_front();
        if (got.id !== want.id)
          report($sformatf("id got %0d want %0d", got.id, want.id));
        if (got.present !== want.present)
          report($sformatf("id %0d present got %0b want %0b", want.id, got.present,
                           want.present));
        if (got.elapsed !== want.elapsed)
          report($sformatf("id %0d elapsed got %0d want %0d", want.id, got.elapsed,
                           want.elapsed));
        if (got.expired !== want.expired)
          report($sformatf("id %0d expired got %0b want %0b", want.id, got.expired,
                           want.expired));
        if (got.last !== want.last)
          report($sformatf("id %0d last got %0b want %0b", want.id, got.last, want.last));
      end
    endtask

    task check_drained();
      if (expected_reports.size() != 0)
        report($sformatf("%0d expected results never arrived", expected_reports.size()));
    endtask

    function int outstanding();
      return expected_reports.size();
    endfunction
  endclass

  // dut connections, all inputs known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // entry_id [5:0], timeout_seconds [21:6], zero pad
  logic [2:0]  s_axis_tuser = '0;   // action [2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // report_id [5:0], present [6], elapsed_seconds [38:7], pad
  logic [0:0]  m_axis_tuser;        // expired [0]
  logic        m_axis_tlast;

  timer_scoreboard sb = new();
  int burst_left = 0;
  int stall_cycle = 0;

  keepalive_timeout_table #(
    .ENTRIES(ID_SPACE)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver back-pressure: rotates through always ready, light random stall,
  // one ready cycle in sixteen, and coin flip
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_cycle   <= 0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      case (stall_cycle[8:7])
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    m_axis_tready <= (stall_cycle[3:0] == 4'd0);
        default: m_axis_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // result monitor: values sampled at the edge, before this edge's updates land
  always @(posedge clk) begin
    timer_report_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.id      = m_axis_tdata[5:0];
      got.present = m_axis_tdata[6];
      got.elapsed = m_axis_tdata[38:7];
      got.expired = m_axis_tuser[0];
      got.last    = m_axis_tlast;
      sb.check_report(got);
    end
  end

  // sender pacing: bursts of random length, random gaps between them
  task pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      // some bursts are long enough to run with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  // present one item and hold it until the block takes it
  task send_request(logic [ACT_W-1:0] act, logic [ID_W-1:0] id, logic [LIMIT_W-1:0] limit);
    pace_sender();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, limit, id};
    s_axis_tuser  <= act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(act, id, limit);
  endtask

  // hold off until every expected result is back
  task wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    logic [ACT_W-1:0]   act;
    logic [ID_W-1:0]    id;
    logic [LIMIT_W-1:0] limit;
    int pick;
    int count;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, overwrite, absent entries, zero limit, ignored code
    send_request(ACT_PRESENCE, 6'd0,  16'h0000);
    send_request(ACT_START,    6'd0,  16'h0000);
    send_request(ACT_START,    6'd63, 16'hFFFF);
    send_request(ACT_START,    6'd0,  16'd3);      // start on a present entry
    send_request(ACT_ELAPSED,  6'd63, 16'h0000);
    send_request(ACT_ELAPSED,  6'd21, 16'h0000);   // absent: no entry created
    send_request(ACT_TICK,     6'd0,  16'h0000);
    send_request(ACT_TICK,     6'd63, 16'hFFFF);
    send_request(ACT_ELAPSED,  6'd63, 16'h0000);
    send_request(ACT_RESTART,  6'd63, 16'h0000);
    send_request(ACT_RESTART,  6'd42, 16'h0000);   // absent
    send_request(ACT_DELETE,   6'd42, 16'h0000);   // absent
    send_request(ACT_PRESENCE, 6'd63, 16'h0000);
    send_request(ACT_UNUSED,   6'd63, 16'hFFFF);
    send_request(ACT_PRESENCE, 6'd21, 16'h0000);   // still absent after the query
    send_request(ACT_START,    6'd21, 16'h0000);   // zero limit
    send_request(ACT_START,    6'd42, 16'd1);
    send_request(ACT_TICK,     6'd0,  16'h0000);
    send_request(ACT_SWEEP,    6'd0,  16'h0000);   // removes 0, 21 and 42
    send_request(ACT_SWEEP,    6'd0,  16'h0000);   // nothing expired
    send_request(ACT_ELAPSED,  6'd63, 16'h0000);
    send_request(ACT_DELETE,   6'd63, 16'h0000);
    send_request(ACT_PRESENCE, 6'd63, 16'h0000);
    send_request(ACT_SWEEP,    6'd0,  16'h0000);   // empty table
    wait_drained();

    // random: mostly a small working set of ids with short limits, so entries
    // get started, age through ticks and expire in sweeps
    count = 0;
    while (count < RANDOM_ITEMS) begin
      if (count == RANDOM_ITEMS / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if      (pick < 20) act = ACT_START;
      else if (pick < 30) act = ACT_ELAPSED;
      else if (pick < 37) act = ACT_DELETE;
      else if (pick < 45) act = ACT_RESTART;
      else if (pick < 53) act = ACT_PRESENCE;
      else if (pick < 65) act = ACT_SWEEP;
      else if (pick < 96) act = ACT_TICK;
      else                act = ACT_UNUSED;
      if ($urandom_range(0, 9) < 7)
        id = ID_W'($urandom_range(0, 7));
      else
        id = ID_W'($urandom_range(0, ID_SPACE - 1));
      pick = $urandom_range(0, 9);
      if      (pick < 6) limit = LIMIT_W'($urandom_range(0, 6));
      else if (pick < 9) limit = LIMIT_W'($urandom_range(0, 40));
      else               limit = LIMIT_W'($urandom_range(0, 16'hFFFF));
      send_request(act, id, limit);
      if (act != ACT_UNUSED) count++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/ktt_pkg.sv
sv/ktt_ram.sv
sv/ktt_ctrl.sv
sv/ktt_datapath.sv
sv/keepalive_timeout_table.sv
tb/keepalive_timeout_table_tb.sv
